// ===== rtl/core/wst_pkg.sv =====
// Shared types and constants for the wheel speed telemetry core.
package wst_pkg;

  localparam int unsigned FRAME_LEN   = 11;
  localparam int unsigned FRAME_IDX_W = $clog2(FRAME_LEN);
  localparam int unsigned DIV_BITS    = 40;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_BITS);
  localparam int unsigned APB_ADDR_W  = 3;

  localparam logic [15:0] SCALE_RESET = 16'd256;

  // register index, taken from paddr[2]
  localparam logic REG_SPEED_SCALE = 1'b0;

  // request types
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  // frame byte values
  localparam logic [7:0] FRM_SOF   = 8'h55;
  localparam logic [7:0] FRM_TYPE  = 8'h02;
  localparam logic [7:0] FRM_LEN   = 8'h06;
  localparam logic [7:0] FRM_END   = 8'hBB;
  localparam logic [7:0] SIGN_POS  = 8'hFF;
  localparam logic [7:0] SIGN_NEG  = 8'h00;

  // frame byte positions
  localparam logic [FRAME_IDX_W-1:0] POS_SOF   = FRAME_IDX_W'(0);
  localparam logic [FRAME_IDX_W-1:0] POS_TYPE  = FRAME_IDX_W'(1);
  localparam logic [FRAME_IDX_W-1:0] POS_LEN   = FRAME_IDX_W'(2);
  localparam logic [FRAME_IDX_W-1:0] POS_LSIGN = FRAME_IDX_W'(3);
  localparam logic [FRAME_IDX_W-1:0] POS_LLO   = FRAME_IDX_W'(4);
  localparam logic [FRAME_IDX_W-1:0] POS_LHI   = FRAME_IDX_W'(5);
  localparam logic [FRAME_IDX_W-1:0] POS_RSIGN = FRAME_IDX_W'(6);
  localparam logic [FRAME_IDX_W-1:0] POS_RLO   = FRAME_IDX_W'(7);
  localparam logic [FRAME_IDX_W-1:0] POS_RHI   = FRAME_IDX_W'(8);
  localparam logic [FRAME_IDX_W-1:0] POS_CK    = FRAME_IDX_W'(9);
  localparam logic [FRAME_IDX_W-1:0] POS_END   = FRAME_IDX_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
  } wst_in_t;

  typedef struct packed {
    logic               is_frame_byte;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [7:0]         frame_byte;
    logic               last;
  } wst_out_t;

  typedef struct packed {
    logic               start;
    logic               report;
    logic signed [31:0] count;
    logic [15:0]        scale;
    logic [15:0]        ticks;
  } lane_cmd_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] speed;
    logic               neg;
    logic [15:0]        mag;
  } lane_stat_t;

  typedef struct packed {
    logic tick;
    logic rep;
  } emit_t;

endpackage

// ===== rtl/core/wst_lane.sv =====
// One wheel lane: delta, accumulator, scale multiply and average divider.
module wst_lane (
  input  logic                clk,
  input  logic                rst,
  input  wst_pkg::lane_cmd_t  cmd,
  output wst_pkg::lane_stat_t stat
);

  typedef enum logic [2:0] {L_IDLE, L_MUL, L_RES, L_DIV, L_SAT} lstate_t;

  lstate_t                          state;
  logic                             op_rep;
  logic [31:0]                      prev;
  logic [31:0]                      sum;
  logic signed [31:0]               opnd;
  logic signed [47:0]               prod;
  logic signed [47:0]               prod_adj;
  logic signed [39:0]               prod_shr;
  logic [47:0]                      prod_abs;
  logic [15:0]                      speed_sat;
  logic [wst_pkg::DIV_BITS-1:0]     divd;
  logic [15:0]                      rem;
  logic [wst_pkg::DIV_CNT_W-1:0]    cnt;
  logic [16:0]                      rem_sh;
  logic [16:0]                      rem_diff;
  logic                             q_bit;

  always_comb begin
    // truncate toward zero: bias negative products before the shift
    prod_adj = prod + (prod[47] ? 48'sd255 : 48'sd0);
    prod_shr = prod_adj[47:8];
    if (prod_shr[39:15] == {25{prod_shr[39]}}) begin
      speed_sat = prod_shr[15:0];
    end else begin
      speed_sat = prod_shr[39] ? 16'h8000 : 16'h7FFF;
    end
    prod_abs = prod[47] ? 48'(-prod) : 48'(prod);
    rem_sh   = {rem, divd[wst_pkg::DIV_BITS-1]};
    rem_diff = rem_sh - {1'b0, cmd.ticks};
    q_bit    = (rem_sh >= {1'b0, cmd.ticks});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= L_IDLE;
      prev      <= '0;
      sum       <= '0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (cmd.start) begin
            op_rep <= cmd.report;
            if (cmd.report) begin
              opnd <= sum;
              sum  <= '0;
            end else begin
              opnd <= cmd.count - prev;
              prev <= cmd.count;
            end
            state <= L_MUL;
          end
        end
        L_MUL: begin
          prod <= opnd * $signed({1'b0, cmd.scale});
          if (!op_rep) begin
            sum <= sum + opnd;
          end
          state <= L_RES;
        end
        L_RES: begin
          if (!op_rep) begin
            stat.speed <= speed_sat;
            stat.done  <= 1'b1;
            state      <= L_IDLE;
          end else if (cmd.ticks == '0) begin
            stat.neg  <= 1'b0;
            stat.mag  <= '0;
            stat.done <= 1'b1;
            state     <= L_IDLE;
          end else begin
            // floor(a / (256 t)) == floor(floor(a / 256) / t)
            stat.neg <= prod[47];
            divd     <= prod_abs[47:8];
            rem      <= '0;
            cnt      <= '0;
            state    <= L_DIV;
          end
        end
        L_DIV: begin
          divd <= {divd[wst_pkg::DIV_BITS-2:0], q_bit};
          rem  <= q_bit ? rem_diff[15:0] : rem_sh[15:0];
          cnt  <= cnt + 1'b1;
          if (cnt == wst_pkg::DIV_CNT_W'(wst_pkg::DIV_BITS - 1)) begin
            state <= L_SAT;
          end
        end
        L_SAT: begin
          stat.mag  <= (divd[wst_pkg::DIV_BITS-1:16] != '0) ? 16'hFFFF : divd[15:0];
          stat.done <= 1'b1;
          state     <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/wst_frame.sv =====
// Merge stage: output register, tick results and report frame serializer.
module wst_frame (
  input  logic                clk,
  input  logic                rst,
  input  wst_pkg::emit_t      emit,
  input  wst_pkg::lane_stat_t lstat,
  input  wst_pkg::lane_stat_t rstat,
  output logic                out_valid,
  input  logic                out_stall,
  output wst_pkg::wst_out_t   out_data,
  output logic                can_load
);

  logic                              active;
  logic [wst_pkg::FRAME_IDX_W-1:0]   idx;
  logic [wst_pkg::FRAME_IDX_W-1:0]   nidx;
  logic [7:0]                        lsb;
  logic [7:0]                        rsb;
  logic [15:0]                       lmag;
  logic [15:0]                       rmag;
  logic [7:0]                        ck;
  logic [7:0]                        nbyte;

  always_comb begin
    ck   = lsb + lmag[7:0] + lmag[15:8] + rsb + rmag[7:0] + rmag[15:8];
    nidx = idx + 1'b1;
    unique case (nidx)
      wst_pkg::POS_SOF:   nbyte = wst_pkg::FRM_SOF;
      wst_pkg::POS_TYPE:  nbyte = wst_pkg::FRM_TYPE;
      wst_pkg::POS_LEN:   nbyte = wst_pkg::FRM_LEN;
      wst_pkg::POS_LSIGN: nbyte = lsb;
      wst_pkg::POS_LLO:   nbyte = lmag[7:0];
      wst_pkg::POS_LHI:   nbyte = lmag[15:8];
      wst_pkg::POS_RSIGN: nbyte = rsb;
      wst_pkg::POS_RLO:   nbyte = rmag[7:0];
      wst_pkg::POS_RHI:   nbyte = rmag[15:8];
      wst_pkg::POS_CK:    nbyte = ck;
      wst_pkg::POS_END:   nbyte = wst_pkg::FRM_END;
      default:            nbyte = wst_pkg::FRM_END;
    endcase
    // free once the request in the register is the final one and leaves
    can_load = !out_valid || (!out_stall && (!active || idx == wst_pkg::POS_END));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      active    <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit.tick) begin
        out_valid              <= 1'b1;
        active                 <= 1'b0;
        out_data.is_frame_byte <= 1'b0;
        out_data.left_speed    <= lstat.speed;
        out_data.right_speed   <= rstat.speed;
        out_data.frame_byte    <= '0;
        out_data.last          <= 1'b1;
      end else if (emit.rep) begin
        out_valid              <= 1'b1;
        active                 <= 1'b1;
        idx                    <= wst_pkg::POS_SOF;
        lsb                    <= lstat.neg ? wst_pkg::SIGN_NEG : wst_pkg::SIGN_POS;
        rsb                    <= rstat.neg ? wst_pkg::SIGN_NEG : wst_pkg::SIGN_POS;
        lmag                   <= lstat.mag;
        rmag                   <= rstat.mag;
        out_data.is_frame_byte <= 1'b1;
        out_data.left_speed    <= '0;
        out_data.right_speed   <= '0;
        out_data.frame_byte    <= wst_pkg::FRM_SOF;
        out_data.last          <= 1'b0;
      end else if (out_valid && !out_stall) begin
        if (active && idx != wst_pkg::POS_END) begin
          idx                 <= nidx;
          out_data.frame_byte <= nbyte;
          out_data.last       <= (nidx == wst_pkg::POS_END);
        end else begin
          out_valid <= 1'b0;
          active    <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/wheel_speed_telemetry_core.sv =====
// Tick request: result goes to the output register; next request taken once it is loaded.
// Report request: each wheel lane averages with the 40-step restoring divider, skipped when no
//   ticks were counted; then one frame byte per cycle (11 bytes) while out_stall is low.
// One request is in the lanes at a time; a new one is taken while the previous results drain.
// Synchronous active-high reset: speed_scale = 256, counts, sums and tick count cleared.
module wheel_speed_telemetry_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  wst_pkg::wst_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output wst_pkg::wst_out_t                 out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wst_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  typedef enum logic [1:0] {T_IDLE, T_LANE, T_EMIT} tstate_t;

  tstate_t               state;
  logic                  op_rep;
  logic [15:0]           scale;
  logic [15:0]           tick_total;
  logic                  in_acc;
  logic                  cfg_wr;
  logic                  can_load;
  wst_pkg::lane_cmd_t    lcmd;
  wst_pkg::lane_cmd_t    rcmd;
  wst_pkg::lane_stat_t   lstat;
  wst_pkg::lane_stat_t   rstat;
  wst_pkg::emit_t        emit;

  always_comb begin
    in_stall    = (state != T_IDLE);
    in_acc      = in_valid && !in_stall;
    pready      = 1'b1;
    cfg_wr      = psel && penable && pwrite && pready &&
                  (paddr[2] == wst_pkg::REG_SPEED_SCALE);
    prdata      = (paddr[2] == wst_pkg::REG_SPEED_SCALE) ? {16'd0, scale} : '0;

    lcmd.start  = in_acc;
    lcmd.report = (in_data.req_type == wst_pkg::REQ_REPORT);
    lcmd.count  = in_data.left_count;
    lcmd.scale  = scale;
    lcmd.ticks  = tick_total;
    rcmd.start  = in_acc;
    rcmd.report = (in_data.req_type == wst_pkg::REQ_REPORT);
    rcmd.count  = in_data.right_count;
    rcmd.scale  = scale;
    rcmd.ticks  = tick_total;

    emit.tick   = (state == T_EMIT) && can_load && !op_rep;
    emit.rep    = (state == T_EMIT) && can_load && op_rep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      scale      <= wst_pkg::SCALE_RESET;
      tick_total <= '0;
    end else begin
      if (cfg_wr) begin
        scale <= pwdata[15:0];
      end
      unique case (state)
        T_IDLE: begin
          if (in_acc) begin
            op_rep <= (in_data.req_type == wst_pkg::REQ_REPORT);
            if (in_data.req_type == wst_pkg::REQ_TICK && tick_total != 16'hFFFF) begin
              tick_total <= tick_total + 16'd1;
            end
            state <= T_LANE;
          end
        end
        T_LANE: begin
          // both lanes run in lockstep
          if (lstat.done && rstat.done) begin
            if (op_rep) begin
              tick_total <= '0;
            end
            state <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (can_load) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  wst_lane u_lane_left (
    .clk  (clk),
    .rst  (rst),
    .cmd  (lcmd),
    .stat (lstat)
  );

  wst_lane u_lane_right (
    .clk  (clk),
    .rst  (rst),
    .cmd  (rcmd),
    .stat (rstat)
  );

  wst_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .lstat     (lstat),
    .rstat     (rstat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .can_load  (can_load)
  );

endmodule

// ===== rtl/core/wst_checker.sv =====
// Port-level checks for the wheel speed telemetry core, with bind.
module wst_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input wst_pkg::wst_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in lanes");

  a_tick_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_frame_byte |-> out_data.last && out_data.frame_byte == '0)
    else $error("tick result malformed");

  a_frame_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_frame_byte && out_data.last |->
      out_data.frame_byte == wst_pkg::FRM_END && out_data.left_speed == '0 &&
      out_data.right_speed == '0)
    else $error("frame does not close with end byte");

endmodule

bind wheel_speed_telemetry_core wst_checker u_wst_checker (.*);
